// ===== src/vn_pkg.sv =====
// Shared widths, payload structs and pipeline lane types for the vector normalizer.
package vn_pkg;

    localparam int VEC_W       = 16;              // Q8.8 input component width
    localparam int SQ_W        = 31;              // one squared magnitude, up to 2^30
    localparam int SUM_W       = 32;              // sum of squares, up to 2^31
    localparam int ROOT_W      = 16;              // root width of a 32-bit radicand
    localparam int REM_W       = ROOT_W + 2;      // partial remainder of the root cells
    localparam int DREM_W      = SUM_W + 1;       // partial remainder of the divide cells
    localparam int QUO_W       = 29;              // quotient of a^2 * 2^28 / s, at most 2^28
    localparam int DIV_STAGES  = QUO_W;           // one quotient bit per cell
    localparam int ROOT_STAGES = ROOT_W;          // one root bit per cell
    localparam int SIDE_STAGES = 2 + DIV_STAGES + ROOT_STAGES;
    localparam int LATENCY     = SIDE_STAGES + 1; // start to done, in cycles

    typedef struct packed {
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
    } vec_in_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] unit_x;
        logic signed [VEC_W-1:0] unit_y;
        logic [VEC_W-1:0]        magnitude;
        logic                    was_zero;
    } result_t;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } div_lane_t;

    typedef struct packed {
        logic [SUM_W-1:0]  val;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_lane_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
    } side_t;

endpackage

// ===== src/vn_div_cell.sv =====
// One restoring-division cell: one quotient bit for the x and y lanes per cycle.
module vn_div_cell
    import vn_pkg::*;
(
    input  logic             clk,
    input  div_lane_t        x_in,
    input  div_lane_t        y_in,
    input  logic [SUM_W-1:0] s_in,
    output div_lane_t        x_out,
    output div_lane_t        y_out,
    output logic [SUM_W-1:0] s_out
);

    div_lane_t        x_reg, x_next;
    div_lane_t        y_reg, y_next;
    logic [SUM_W-1:0] s_reg;

    // Compare against the divisor, subtract when it fits, and shift for the next cell.
    function automatic div_lane_t div_step(div_lane_t l, logic [SUM_W-1:0] d);
        logic [DREM_W-1:0] dx;
        logic              ge;
        logic [DREM_W-1:0] diff;
        div_lane_t         o;
        dx    = {1'b0, d};
        ge    = (l.rem >= dx);
        diff  = ge ? (l.rem - dx) : l.rem;
        o.rem = {diff[DREM_W-2:0], 1'b0};
        o.quo = {l.quo[QUO_W-2:0], ge};
        return o;
    endfunction

    always_comb
    begin
        x_next = div_step(x_in, s_in);
        y_next = div_step(y_in, s_in);
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        s_reg <= s_in;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign s_out = s_reg;

endmodule

// ===== src/vn_root_cell.sv =====
// One digit-by-digit square root cell: one root bit per cycle.
module vn_root_cell
    import vn_pkg::*;
(
    input  logic       clk,
    input  root_lane_t lane_in,
    output root_lane_t lane_out
);

    root_lane_t       lane_reg, lane_next;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] cand;
    logic             ge;

    always_comb
    begin
        // Bring down the next two radicand bits and try the root bit as one.
        cand           = {lane_in.rem[REM_W-3:0], lane_in.val[SUM_W-1:SUM_W-2]};
        trial          = {lane_in.root, 2'b01};
        ge             = (cand >= trial);
        lane_next.rem  = ge ? (cand - trial) : cand;
        lane_next.root = {lane_in.root[ROOT_W-2:0], ge};
        lane_next.val  = {lane_in.val[SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

// ===== src/vector2_normalize.sv =====
// Top level of the two-dimensional vector normalizer: squares, divide chain, root chain.
//
//   channel | handshake            | payload          | notes
//   --------+----------------------+------------------+------------------------------
//   input   | start, busy          | vec (vec_in_t)   | taken when start && !busy
//   result  | done                 | result(result_t) | valid for one cycle, no stall
//
// A new transaction is taken in every cycle; busy never rises.
// Each transaction passes through the squaring register, the summing register,
// 29 divide cells and 16 root cells, then the output register, before it appears on
// result. The cell chains hold no feedback, so the rate is one transaction per cycle.
// Reset clears only the valid chain and done.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module vector2_normalize
    import vn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  vec_in_t vec,
    output logic    done,
    output result_t result
);

    logic                    accept;
    logic [VEC_W-1:0]        ax;
    logic [VEC_W-1:0]        ay;

    // Squaring stage and summing stage.
    logic [SQ_W-1:0]         a2x_reg, a2y_reg;
    logic [SQ_W-1:0]         a2x1_reg, a2y1_reg;
    logic [SUM_W-1:0]        s_reg;

    // Side information and valid flags travel alongside the cell chains.
    side_t                   side_reg [SIDE_STAGES];
    logic [SIDE_STAGES-1:0]  valid_reg;

    // Links between the cells.
    div_lane_t               dx_link [DIV_STAGES+1];
    div_lane_t               dy_link [DIV_STAGES+1];
    logic [SUM_W-1:0]        ds_link [DIV_STAGES+1];
    root_lane_t              rm_link [ROOT_STAGES+1];
    root_lane_t              rx_link [ROOT_STAGES+1];
    root_lane_t              ry_link [ROOT_STAGES+1];

    result_t                 result_reg, result_next;
    logic                    done_reg;
    side_t                   side_last;
    logic [ROOT_W-1:0]       ux_mag, uy_mag;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Absolute values; -32768 maps to 32768, which still fits 16 unsigned bits.
    assign ax = vec.vec_x[VEC_W-1] ? (~vec.vec_x + 1'b1) : vec.vec_x;
    assign ay = vec.vec_y[VEC_W-1] ? (~vec.vec_y + 1'b1) : vec.vec_y;

    always_ff @(posedge clk)
    begin
        a2x_reg  <= SQ_W'(ax * ax);
        a2y_reg  <= SQ_W'(ay * ay);
        a2x1_reg <= a2x_reg;
        a2y1_reg <= a2y_reg;
        s_reg    <= SUM_W'(a2x_reg) + SUM_W'(a2y_reg);
    end

    always_ff @(posedge clk)
    begin
        side_reg[0].neg_x <= vec.vec_x[VEC_W-1];
        side_reg[0].neg_y <= vec.vec_y[VEC_W-1];
        side_reg[0].zero  <= (vec.vec_x == '0) && (vec.vec_y == '0);
        for (int i = 1; i < SIDE_STAGES; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[SIDE_STAGES-2:0], accept};
        end
    end

    // Each unit component is floor(sqrt(floor(a^2 * 2^28 / s))). The divide chain
    // starts from a^2, which never exceeds s, so the quotient is at most 2^28.
    assign dx_link[0].rem = DREM_W'(a2x1_reg);
    assign dx_link[0].quo = '0;
    assign dy_link[0].rem = DREM_W'(a2y1_reg);
    assign dy_link[0].quo = '0;
    assign ds_link[0]     = s_reg;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        vn_div_cell u_div (
            .clk   (clk),
            .x_in  (dx_link[g]),
            .y_in  (dy_link[g]),
            .s_in  (ds_link[g]),
            .x_out (dx_link[g+1]),
            .y_out (dy_link[g+1]),
            .s_out (ds_link[g+1])
        );
    end

    // Three root chains run side by side: the length and the two unit magnitudes.
    assign rm_link[0].val  = ds_link[DIV_STAGES];
    assign rm_link[0].rem  = '0;
    assign rm_link[0].root = '0;
    assign rx_link[0].val  = SUM_W'(dx_link[DIV_STAGES].quo);
    assign rx_link[0].rem  = '0;
    assign rx_link[0].root = '0;
    assign ry_link[0].val  = SUM_W'(dy_link[DIV_STAGES].quo);
    assign ry_link[0].rem  = '0;
    assign ry_link[0].root = '0;

    for (genvar g = 0; g < ROOT_STAGES; g++)
    begin : g_root
        vn_root_cell u_mag (
            .clk      (clk),
            .lane_in  (rm_link[g]),
            .lane_out (rm_link[g+1])
        );
        vn_root_cell u_ux (
            .clk      (clk),
            .lane_in  (rx_link[g]),
            .lane_out (rx_link[g+1])
        );
        vn_root_cell u_uy (
            .clk      (clk),
            .lane_in  (ry_link[g]),
            .lane_out (ry_link[g+1])
        );
    end

    // Restore the signs; a zero vector forces both unit fields to zero.
    assign side_last = side_reg[SIDE_STAGES-1];
    assign ux_mag    = rx_link[ROOT_STAGES].root;
    assign uy_mag    = ry_link[ROOT_STAGES].root;

    always_comb
    begin
        result_next.unit_x    = side_last.neg_x ? (~ux_mag + 1'b1) : ux_mag;
        result_next.unit_y    = side_last.neg_y ? (~uy_mag + 1'b1) : uy_mag;
        result_next.magnitude = rm_link[ROOT_STAGES].root;
        result_next.was_zero  = side_last.zero;
        if (side_last.zero)
        begin
            result_next.unit_x = '0;
            result_next.unit_y = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[SIDE_STAGES-1];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // Every accepted transaction comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("transaction did not complete after the pipeline latency");

    // A result never appears without a transaction that entered the pipeline.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg[SIDE_STAGES-1]))
        else $error("result strobe without a matching transaction");

    // A nonzero vector has a length of at least one least significant bit.
    a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.was_zero |-> result.magnitude != '0)
        else $error("nonzero vector gave zero length");

    // A zero vector gives zero length and zero unit components.
    a_zero_case: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.was_zero |->
            result.magnitude == '0 && result.unit_x == '0 && result.unit_y == '0)
        else $error("zero vector gave nonzero fields");

    // Unit components stay within plus or minus one in Q2.14.
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.unit_x <= 16'sd16384 && result.unit_x >= -16'sd16384 &&
                 result.unit_y <= 16'sd16384 && result.unit_y >= -16'sd16384)
        else $error("unit component out of range");
`endif

endmodule
